@@ rtl/ptw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int LEVELS            = 4;
  localparam int IDX_W             = 9;
  localparam int OFF_W             = 12;
  localparam int FRAME_W           = 40;
  localparam int ENTRY_W           = 42;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int STATUS_W          = 2;

  // Entry layout: frame number above two flag bits.
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_WRITE_BIT   = 1;

  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_MAP       = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_TABLES = 2'd2;

  typedef enum logic {
    FU_SUB = 1'b0,
    FU_ADD = 1'b1
  } fu_op_t;

  typedef struct packed {
    fu_op_t             op;
    logic [FRAME_W-1:0] a;
    logic [FRAME_W-1:0] b;
  } fu_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] sum;
    logic               in_range;
  } fu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/ptw_table_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptw_table_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [ptw_pkg::ENTRY_W-1:0] wdata,
  output logic      [ptw_pkg::ENTRY_W-1:0] rdata
);
  import ptw_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptw_frame_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared 40-bit frame adder. In subtract mode it gives an entry's offset
// from the pool base and whether that offset lands on a pool page; in add
// mode it forms the frame number of a newly allocated table page.
module ptw_frame_unit #(
  parameter int NUM_TABLE_PAGES = 64
) (
  input  wire ptw_pkg::fu_req_t req,
  output ptw_pkg::fu_rsp_t      rsp
);
  import ptw_pkg::*;

  logic [FRAME_W-1:0] b_eff;
  logic [FRAME_W-1:0] sum;

  always_comb begin
    b_eff = (req.op == FU_SUB) ? ~req.b : req.b;
    sum   = req.a + b_eff + {{(FRAME_W-1){1'b0}}, (req.op == FU_SUB)};
    rsp.sum      = sum;
    rsp.in_range = (sum < FRAME_W'(NUM_TABLE_PAGES));
  end

endmodule

`default_nettype wire

@@ rtl/four_level_page_table_walker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  action, vaddr, paddr
// out      output     out_valid / out_stall result_addr, status
// cfg      input      cfg_valid / cfg_ready pool_base_frame
//
// A translate item passes through the accept, a table read and an adder
// evaluation per level, and the hand-off; a map item writes its leaf in
// place of the last read and adds a write for each table page it allocates.
// Failed walks end early. After reset a clearing pass writes zero to every
// entry, one per cycle, while in_stall is held high.
// A waiting result holds the output register; the next walk runs meanwhile.
module four_level_page_table_walker_unit #(
  parameter int NUM_TABLE_PAGES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [ptw_pkg::VA_W-1:0]      vaddr,
  input  wire logic [ptw_pkg::PA_W-1:0]      paddr,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ptw_pkg::PA_W-1:0]      result_addr,
  output logic      [ptw_pkg::STATUS_W-1:0]  status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ptw_pkg::FRAME_W-1:0]   pool_base_frame
);
  import ptw_pkg::*;

  localparam int PW    = (NUM_TABLE_PAGES > 1) ? $clog2(NUM_TABLE_PAGES) : 1;
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = NUM_TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam logic [1:0] LAST_LVL = 2'(LEVELS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_ALLOC = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]       clr_cnt, clr_cnt_next;
  logic [1:0]          lvl, lvl_next;
  logic [PW-1:0]       page, page_next;
  logic [PW:0]         next_free, next_free_next;
  logic                act;
  logic [VA_W-1:0]     va;
  logic [FRAME_W-1:0]  pa_frame;
  logic [FRAME_W-1:0]  pool_base;
  logic [PA_W-1:0]     res_addr, res_addr_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                out_valid_next;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [IDX_W-1:0]    walk_idx;
  logic [AW-1:0]       walk_addr;
  logic                present, in_pool, out_free;

  fu_req_t fu_req;
  fu_rsp_t fu_rsp;

  ptw_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ptw_frame_unit #(
    .NUM_TABLE_PAGES (NUM_TABLE_PAGES)
  ) u_fu (
    .req (fu_req),
    .rsp (fu_rsp)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign walk_idx  = va[OFF_W + IDX_W * (LEVELS - 1 - int'(lvl)) +: IDX_W];
  assign walk_addr = {page, walk_idx};
  assign present   = ram_rdata[FLAG_PRESENT_BIT];
  assign in_pool   = present && fu_rsp.in_range;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    fu_req.op = FU_SUB;
    fu_req.a  = ram_rdata[ENTRY_W-1:2];
    fu_req.b  = pool_base;
    if (state == S_ALLOC) begin
      fu_req.op = FU_ADD;
      fu_req.a  = pool_base;
      fu_req.b  = FRAME_W'(next_free);
    end
  end

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    lvl_next        = lvl;
    page_next       = page;
    next_free_next  = next_free;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_addr        = walk_addr;
    ram_wdata       = '0;

    case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        lvl_next  = '0;
        page_next = '0;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (act == ACT_MAP && lvl == LAST_LVL) begin
          // Leaf write: the frame is installed present and writable.
          ram_we          = 1'b1;
          ram_wdata       = {pa_frame, 1'b1, 1'b1};
          res_addr_next   = {pa_frame, {OFF_W{1'b0}}};
          res_status_next = STATUS_OK;
          state_next      = S_DONE;
        end else begin
          ram_re     = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (act == ACT_TRANSLATE && lvl == LAST_LVL) begin
          if (present) begin
            res_addr_next   = {ram_rdata[ENTRY_W-1:2], va[OFF_W-1:0]};
            res_status_next = STATUS_OK;
          end else begin
            res_addr_next   = '0;
            res_status_next = STATUS_NOT_MAPPED;
          end
          state_next = S_DONE;
        end else if (in_pool) begin
          page_next  = fu_rsp.sum[PW-1:0];
          lvl_next   = lvl + 2'd1;
          state_next = S_READ;
        end else if (act == ACT_TRANSLATE) begin
          res_addr_next   = '0;
          res_status_next = STATUS_NOT_MAPPED;
          state_next      = S_DONE;
        end else if (next_free >= (PW+1)'(NUM_TABLE_PAGES)) begin
          res_addr_next   = '0;
          res_status_next = STATUS_OUT_OF_TABLES;
          state_next      = S_DONE;
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // Pages past next_free hold the zeros of the clearing pass, so the new one is zero.
        ram_we         = 1'b1;
        ram_wdata      = {fu_rsp.sum, 1'b1, 1'b1};
        page_next      = next_free[PW-1:0];
        next_free_next = next_free + 1'b1;
        lvl_next       = lvl + 2'd1;
        state_next     = S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == S_DONE && out_free) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= (PW+1)'(1);
      out_valid <= 1'b0;
      pool_base <= '0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      next_free <= next_free_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        pool_base <= pool_base_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl        <= lvl_next;
    page       <= page_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (state == S_IDLE && in_valid) begin
      act      <= action;
      va       <= vaddr;
      pa_frame <= paddr[PA_W-1:OFF_W];
    end
    if (state == S_DONE && out_free) begin
      result_addr <= res_addr;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ptw_pkg::PA_W-1:0]      result_addr,
  input wire logic [ptw_pkg::STATUS_W-1:0]  status
);
  import ptw_pkg::*;

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("stalled result item changed");

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_NOT_MAPPED ||
                   status == STATUS_OUT_OF_TABLES))
    else $error("undefined status code");

  // Failed walks report a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> result_addr == '0)
    else $error("failed walk with nonzero address");

  // The walker is busy on the cycle after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("walker took an item while busy");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_addr (result_addr),
  .status      (status)
);

`default_nettype wire

@@ tb/page_walk_checker.sv @@
`timescale 1ns / 1ps

module page_walk_checker #(
  parameter int NUM_TABLE_PAGES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         action,
  input  logic [ptw_pkg::VA_W-1:0]     vaddr,
  input  logic [ptw_pkg::PA_W-1:0]     paddr,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ptw_pkg::PA_W-1:0]     result_addr,
  input  logic [ptw_pkg::STATUS_W-1:0] status,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ptw_pkg::FRAME_W-1:0]  pool_base_frame,
  output int                           mismatch_count,
  output int                           results_due
);
  import ptw_pkg::*;

  localparam int TABLE_SLOTS = NUM_TABLE_PAGES * ENTRIES_PER_TABLE;

  typedef struct packed {
    logic [PA_W-1:0]     addr;
    logic [STATUS_W-1:0] status;
  } walk_result_t;

  logic [ENTRY_W-1:0] page_entries [0:TABLE_SLOTS-1];
  int                 next_free_page;
  logic [FRAME_W-1:0] pool_base;
  walk_result_t       walk_results_due [$];
  walk_result_t       predicted;
  walk_result_t       oldest;

  function automatic logic [ENTRY_W-1:0] make_table_entry(input logic [FRAME_W-1:0] frame);
    logic [ENTRY_W-1:0] ent;
    ent = '0;
    ent[ENTRY_W-1:2] = frame;
    ent[FLAG_PRESENT_BIT] = 1'b1;
    ent[FLAG_WRITE_BIT] = 1'b1;
    return ent;
  endfunction

  // Pool page an entry points to, or -1 when it is absent or lies outside the pool.
  function automatic int pool_page_of(input logic [ENTRY_W-1:0] ent);
    logic [FRAME_W-1:0] page;
    if (!ent[FLAG_PRESENT_BIT]) return -1;
    page = ent[ENTRY_W-1:2] - pool_base;
    if (page >= NUM_TABLE_PAGES) return -1;
    return int'(page);
  endfunction

  task automatic walk_tables(input logic act, input logic [VA_W-1:0] va,
                             input logic [PA_W-1:0] pa, output walk_result_t res);
    logic [IDX_W-1:0]   idx [LEVELS];
    logic [FRAME_W-1:0] frame;
    int                 page;
    int                 nxt;
    int                 slot_no;
    idx[0] = va[47:39];
    idx[1] = va[38:30];
    idx[2] = va[29:21];
    idx[3] = va[20:12];
    res.addr = '0;
    res.status = STATUS_OK;
    page = 0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      slot_no = page * ENTRIES_PER_TABLE + int'(idx[lvl]);
      nxt = pool_page_of(page_entries[slot_no]);
      if (nxt < 0) begin
        if (act == ACT_TRANSLATE) begin
          res.status = STATUS_NOT_MAPPED;
          return;
        end
        if (next_free_page >= NUM_TABLE_PAGES) begin
          res.status = STATUS_OUT_OF_TABLES;
          return;
        end
        nxt = next_free_page;
        next_free_page++;
        frame = pool_base + nxt;
        page_entries[slot_no] = make_table_entry(frame);
      end
      page = nxt;
    end
    slot_no = page * ENTRIES_PER_TABLE + int'(idx[3]);
    if (act == ACT_TRANSLATE) begin
      if (!page_entries[slot_no][FLAG_PRESENT_BIT]) begin
        res.status = STATUS_NOT_MAPPED;
      end else begin
        res.addr = {page_entries[slot_no][ENTRY_W-1:2], va[OFF_W-1:0]};
      end
    end else begin
      page_entries[slot_no] = make_table_entry(pa[PA_W-1:OFF_W]);
      res.addr = {pa[PA_W-1:OFF_W], {OFF_W{1'b0}}};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) page_entries[i] = '0;
      next_free_page = 1;
      pool_base = '0;
      walk_results_due.delete();
      mismatch_count = 0;
      results_due <= 0;
    end else begin
      // Register writes only happen while no item is in flight.
      if (cfg_valid && cfg_ready) pool_base = pool_base_frame;
      if (in_valid && !in_stall) begin
        walk_tables(action, vaddr, paddr, predicted);
        walk_results_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (walk_results_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("result with no item outstanding: addr %h status %0d",
                     result_addr, status);
          mismatch_count++;
        end else begin
          oldest = walk_results_due.pop_front();
          if (result_addr !== oldest.addr || status !== oldest.status) begin
            if (mismatch_count < 10)
              $display("walk mismatch: expected addr %h status %0d, got addr %h status %0d",
                       oldest.addr, oldest.status, result_addr, status);
            mismatch_count++;
          end
        end
      end
      results_due <= walk_results_due.size();
    end
  end

endmodule

@@ tb/four_level_page_table_walker_unit_tb.sv @@
`timescale 1ns / 1ps

module four_level_page_table_walker_unit_tb;
  import ptw_pkg::*;

  localparam int TABLE_PAGES    = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_GAP      = 32;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                action;
  logic [VA_W-1:0]     vaddr;
  logic [PA_W-1:0]     paddr;
  logic                out_valid;
  logic                out_stall;
  logic [PA_W-1:0]     result_addr;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FRAME_W-1:0]  pool_base_frame;

  int mismatch_count;
  int results_due;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [VA_W-1:0] hot_vas [$];

  four_level_page_table_walker_unit #(
    .NUM_TABLE_PAGES(TABLE_PAGES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .vaddr(vaddr),
    .paddr(paddr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_addr(result_addr),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .pool_base_frame(pool_base_frame)
  );

  page_walk_checker #(
    .NUM_TABLE_PAGES(TABLE_PAGES)
  ) walk_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .vaddr(vaddr),
    .paddr(paddr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_addr(result_addr),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .pool_base_frame(pool_base_frame),
    .mismatch_count(mismatch_count),
    .results_due(results_due)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Cycles with no handshake on any channel; the clearing pass after reset counts too.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic [VA_W-1:0] va,
                           input logic [PA_W-1:0] pa);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    vaddr <= va;
    paddr <= pa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_pool_base(input logic [FRAME_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    pool_base_frame <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly walks along paths already built, so leaves get written and read back;
  // a few items branch off at a shallower level or take a fresh address.
  task automatic make_random_item(output logic act, output logic [VA_W-1:0] va,
                                  output logic [PA_W-1:0] pa);
    int              pick;
    logic [63:0]     r64;
    logic [VA_W-1:0] base_va;
    pick = $urandom_range(0, 99);
    act = ($urandom_range(0, 1) == 1) ? ACT_MAP : ACT_TRANSLATE;
    r64 = {$urandom, $urandom};
    pa = {r64[19:0], r64[63:32]};
    r64 = {$urandom, $urandom};
    if (hot_vas.size() == 0 || pick < 3) begin
      va = r64[VA_W-1:0];
    end else begin
      base_va = hot_vas[$urandom_range(0, hot_vas.size() - 1)];
      if (pick < 8) va = {base_va[47:39], r64[38:0]};
      else if (pick < 30) va = {base_va[47:21], r64[20:0]};
      else va = {base_va[47:12], r64[11:0]};
    end
    if (act == ACT_MAP && pick < 8 && hot_vas.size() < 32) hot_vas.push_back(va);
  endtask

  task automatic run_random(input int count);
    logic            act;
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;
    for (int i = 0; i < count; i++) begin
      // Halfway through, the sender holds off until every result is back.
      if (i == count / 2) drain_results();
      make_random_item(act, va, pa);
      send_item(act, va, pa);
    end
  endtask

  initial begin
    logic [VA_W-1:0]    burst_vas [$];
    logic [FRAME_W-1:0] scattered_base;
    logic [63:0]        r64;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_TRANSLATE;
    vaddr = '0;
    paddr = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    pool_base_frame = '0;
    fork
      begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst <= 1'b0;

        // Pool at the top frame, so later pool pages wrap around to frame 0.
        write_pool_base({FRAME_W{1'b1}});
        send_item(ACT_TRANSLATE, 48'h0, 52'h0);
        send_item(ACT_TRANSLATE, {VA_W{1'b1}}, 52'h0);
        send_item(ACT_MAP, 48'h0, {PA_W{1'b1}});
        send_item(ACT_TRANSLATE, 48'h0000_0000_0FFF, 52'h0);
        send_item(ACT_TRANSLATE, 48'h0000_0000_1000, 52'h0);
        send_item(ACT_MAP, {VA_W{1'b1}}, 52'h0);
        send_item(ACT_TRANSLATE, {VA_W{1'b1}}, {PA_W{1'b1}});
        // Remapping overwrites the leaf.
        send_item(ACT_MAP, 48'h0000_0000_0000, 52'h1_2345_6789_ABCD);
        send_item(ACT_TRANSLATE, 48'h0000_0000_0ABC, 52'h0);
        // Second level missing under a present root entry.
        send_item(ACT_TRANSLATE, 48'h0000_4000_0000, 52'h0);
        send_item(ACT_MAP, 48'h0000_4000_0000, 52'h0_00A5_5A5A_5000);
        // Third level missing.
        send_item(ACT_TRANSLATE, 48'h0000_0020_0000, 52'h0);
        send_item(ACT_MAP, 48'h8000_0000_0000, 52'h8_0000_0000_0000);
        send_item(ACT_TRANSLATE, 48'h8000_0000_0123, 52'h0);
        hot_vas.push_back(48'h0);
        hot_vas.push_back({VA_W{1'b1}});
        hot_vas.push_back(48'h0000_4000_0000);
        hot_vas.push_back(48'h8000_0000_0000);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(190);

        // Shifting the base by one makes existing entries point one page lower.
        write_pool_base('0);
        send_idle_pct = 49;
        recv_stall_pct = 0;
        run_random(190);

        // A far base puts every entry outside the pool; maps rebuild until it runs dry.
        r64 = {$urandom, $urandom};
        scattered_base = r64[FRAME_W-1:0] | 40'h80_0000_0000;
        write_pool_base(scattered_base);
        send_idle_pct = 0;
        recv_stall_pct = 49;
        for (int k = 0; k < 24; k++) begin
          r64 = {$urandom, $urandom};
          burst_vas.push_back({9'(300 + k), r64[38:0]});
          send_item(ACT_MAP, burst_vas[k], {r64[63:44], $urandom});
        end
        for (int k = 0; k < 24; k++) begin
          send_item(ACT_TRANSLATE, {burst_vas[k][47:12], 12'($urandom)}, 52'h0);
        end
        run_random(150);

        write_pool_base(scattered_base - 1);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        run_random(190);

        drain_results();
      end
      wait (idle_cycles >= WATCHDOG_LIMIT);
    join_any
    if (idle_cycles >= WATCHDOG_LIMIT || mismatch_count != 0 || results_due != 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule
